[hdl/bsc_pkg.sv]
// Package with shared constants and pipeline types for the barometric compensation block.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam logic [31:0] TEMP_ROUND      = 32'd128;
  localparam logic [31:0] PRESS_OFFSET    = 32'd64000;
  localparam logic [31:0] PRESS_FULLSCALE = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE     = 32'd3125;
  localparam logic [31:0] PRESS_HALF      = 32'h8000_0000;
  localparam logic [31:0] DIV_BIAS        = 32'd32768;
  localparam int unsigned DIV_BITS        = 32;

  typedef enum logic [1:0] {
    REG_TEMP_CAL = 2'd0,
    REG_PRESS_A  = 2'd1,
    REG_PRESS_B  = 2'd2,
    REG_PRESS_P9 = 2'd3
  } reg_index_t;

  // Side information carried alongside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic        zero_div;
    logic        big;
  } div_tag_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction
endpackage

[hdl/bsc_divider.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bsc_divider #(
  parameter int unsigned TAG_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [31:0]      dividend,
  input  logic [31:0]      divisor,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      quotient,
  output logic [TAG_W-1:0] out_tag
);
  localparam int unsigned N = bsc_pkg::DIV_BITS;

  logic [N:0]      vld;
  logic [31:0]     num [N+1];
  logic [31:0]     den [N+1];
  logic [32:0]     rem [N+1];
  logic [TAG_W-1:0] tag [N+1];

  always_comb begin
    vld[0] = in_valid;
    num[0] = dividend;
    den[0] = divisor;
    rem[0] = '0;
    tag[0] = in_tag;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem[i][31:0], num[i][31]};
    assign diff  = trial - {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      den[i+1] <= den[i];
      tag[i+1] <= tag[i];
      // The dividend shifts out from the top while quotient bits enter at the bottom.
      if (!diff[32]) begin
        rem[i+1] <= diff;
        num[i+1] <= {num[i][30:0], 1'b1};
      end else begin
        rem[i+1] <= trial;
        num[i+1] <= {num[i][30:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = num[N];
  assign out_tag   = tag[N];
endmodule

[hdl/barometric_sensor_compensation.sv]
// Barometric compensation: one transaction per cycle.
// Throughput is set by the 32-stage divider pipeline, which accepts an item every cycle.
// busy is always low; done pulses for exactly one cycle per transaction, no back-pressure.
// Synchronous reset clears valid bits and calibration registers to zero.
`timescale 1ns / 1ps
module barometric_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_pa,
  output logic               pressure_valid
);
  logic [47:0] temp_cal;
  logic [63:0] press_a, press_b;
  logic [15:0] press_p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0; press_a <= '0; press_b <= '0; press_p9 <= '0;
    end else if (cfg_we) begin
      unique case (bsc_pkg::reg_index_t'(cfg_index))
        bsc_pkg::REG_TEMP_CAL: temp_cal <= cfg_data[47:0];
        bsc_pkg::REG_PRESS_A:  press_a  <= cfg_data;
        bsc_pkg::REG_PRESS_B:  press_b  <= cfg_data;
        bsc_pkg::REG_PRESS_P9: press_p9 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_cal[15:0]};
  assign t2 = bsc_pkg::sx16(temp_cal[31:16]);
  assign t3 = bsc_pkg::sx16(temp_cal[47:32]);
  assign p1 = {16'd0, press_a[15:0]};
  assign p2 = bsc_pkg::sx16(press_a[31:16]);
  assign p3 = bsc_pkg::sx16(press_a[47:32]);
  assign p4 = bsc_pkg::sx16(press_a[63:48]);
  assign p5 = bsc_pkg::sx16(press_b[15:0]);
  assign p6 = bsc_pkg::sx16(press_b[31:16]);
  assign p7 = bsc_pkg::sx16(press_b[47:32]);
  assign p8 = bsc_pkg::sx16(press_b[63:48]);
  assign p9 = bsc_pkg::sx16(press_p9);

  // Stage 1: temperature differences.
  logic        v1;
  logic [31:0] s1_ta, s1_d;
  logic [19:0] s1_rp;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    s1_ta <= {15'd0, raw_temperature[19:3]} - (t1 << 1);
    s1_d  <= {16'd0, raw_temperature[19:4]} - t1;
    s1_rp <= raw_pressure;
  end

  // Stage 2: products a and d*d.
  logic        v2;
  logic [31:0] s2_a, s2_dd;
  logic [19:0] s2_rp;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    s2_a  <= 32'($signed(s1_ta * t2) >>> 11);
    s2_dd <= s1_d * s1_d;
    s2_rp <= s1_rp;
  end

  // Stage 3: b term.
  logic        v3;
  logic [31:0] s3_a, s3_bm;
  logic [19:0] s3_rp;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s3_a  <= s2_a;
    s3_bm <= 32'($signed(s2_dd) >>> 12) * t3;
    s3_rp <= s2_rp;
  end

  // Stage 4: fine temperature.
  logic        v4;
  logic [31:0] s4_tf;
  logic [19:0] s4_rp;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    s4_tf <= s3_a + 32'($signed(s3_bm) >>> 14);
    s4_rp <= s3_rp;
  end

  // Stage 5: temperature output and var3.
  logic        v5;
  logic [31:0] s5_temp, s5_v3, s5_q;
  logic [19:0] s5_rp;
  logic [31:0] tf5, v3c;
  assign tf5 = s4_tf * 32'd5 + bsc_pkg::TEMP_ROUND;
  assign v3c = 32'($signed(s4_tf) >>> 1) - bsc_pkg::PRESS_OFFSET;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    s5_temp <= 32'($signed(tf5) >>> 8);
    s5_v3   <= v3c;
    s5_q    <= 32'($signed(v3c) >>> 2);
    s5_rp   <= s4_rp;
  end

  // Stage 6: qq and the linear products.
  logic        v6;
  logic [31:0] s6_temp, s6_qq, s6_v3p5, s6_p2v3;
  logic [19:0] s6_rp;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    s6_temp <= s5_temp;
    s6_qq   <= s5_q * s5_q;
    s6_v3p5 <= s5_v3 * p5;
    s6_p2v3 <= p2 * s5_v3;
    s6_rp   <= s5_rp;
  end

  // Stage 7: qq products.
  logic        v7;
  logic [31:0] s7_temp, s7_q6, s7_p3q, s7_v3p5, s7_p2v3;
  logic [19:0] s7_rp;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    s7_temp <= s6_temp;
    s7_q6   <= 32'($signed(s6_qq) >>> 11) * p6;
    s7_p3q  <= p3 * 32'($signed(s6_qq) >>> 13);
    s7_v3p5 <= s6_v3p5;
    s7_p2v3 <= s6_p2v3;
    s7_rp   <= s6_rp;
  end

  // Stage 8: var4 and the divisor term.
  logic        v8;
  logic [31:0] s8_temp, s8_v4, s8_v3;
  logic [19:0] s8_rp;
  logic [31:0] v4s, v3s;
  assign v4s = s7_q6 + (s7_v3p5 << 1);
  assign v3s = 32'($signed(s7_p3q) >>> 3) + 32'($signed(s7_p2v3) >>> 1);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else v8 <= v7;
    s8_temp <= s7_temp;
    s8_v4   <= 32'($signed(v4s) >>> 2) + (p4 << 16);
    s8_v3   <= 32'($signed(v3s) >>> 18);
    s8_rp   <= s7_rp;
  end

  // Stage 9: divisor product and pressure difference.
  logic        v9;
  logic [31:0] s9_temp, s9_divm, s9_pd;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else v9 <= v8;
    s9_temp <= s8_temp;
    s9_divm <= (bsc_pkg::DIV_BIAS + s8_v3) * p1;
    s9_pd   <= (bsc_pkg::PRESS_FULLSCALE - {12'd0, s8_rp}) - 32'($signed(s8_v4) >>> 12);
  end

  // Stage 10: scaled dividend and divisor.
  logic        v10;
  logic [31:0] s10_temp, s10_div, s10_p;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else v10 <= v9;
    s10_temp <= s9_temp;
    s10_div  <= 32'($signed(s9_divm) >>> 15);
    s10_p    <= s9_pd * bsc_pkg::PRESS_SCALE;
  end

  bsc_pkg::div_tag_t in_tag, out_tag;
  logic              big;
  logic [31:0]       dvd, quo;
  logic              dv_valid;
  assign big = s10_p >= bsc_pkg::PRESS_HALF;
  assign dvd = big ? s10_p : (s10_p << 1);
  assign in_tag = '{temp: s10_temp, zero_div: (s10_div == 32'd0), big: big};

  bsc_divider #(.TAG_W($bits(bsc_pkg::div_tag_t))) u_div (
    .clk(clk), .rst(rst), .in_valid(v10),
    .dividend(dvd), .divisor(s10_div), .in_tag(in_tag),
    .out_valid(dv_valid), .quotient(quo), .out_tag(out_tag)
  );

  // Post stage A: final quotient and squared term.
  logic        va;
  logic [31:0] sa_p, sa_ss, sa_p8, sa_temp;
  logic        sa_zero;
  logic [31:0] pq, sq;
  assign pq = out_tag.big ? (quo << 1) : quo;
  assign sq = pq >> 3;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= dv_valid;
    sa_p    <= pq;
    sa_ss   <= sq * sq;
    sa_p8   <= (pq >> 2) * p8;
    sa_temp <= out_tag.temp;
    sa_zero <= out_tag.zero_div;
  end

  // Post stage B: P9 and P8 correction terms.
  logic        vb;
  logic [31:0] sb_p, sb_c1m, sb_c2, sb_temp;
  logic        sb_zero;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    sb_p    <= sa_p;
    sb_c1m  <= p9 * (sa_ss >> 13);
    sb_c2   <= 32'($signed(sa_p8) >>> 13);
    sb_temp <= sa_temp;
    sb_zero <= sa_zero;
  end

  // Post stage C: final sum into the result registers.
  logic [31:0] corr;
  assign corr = 32'($signed(sb_c1m) >>> 12) + sb_c2 + p7;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vb;
    temperature_centi <= $signed(sb_temp);
    pressure_pa       <= sb_zero ? 32'd0 : sb_p + 32'($signed(corr) >>> 4);
    pressure_valid    <= !sb_zero;
  end

  // A zero divisor always reports zero pressure.
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    done && !pressure_valid |-> pressure_pa == 32'd0) else $error("zero divisor nonzero pressure");
  // Pipeline latency: a valid entering the divider shows up as done after the divider and post stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(v10, 35) && !$past(rst, 35) && !$past(rst, 1) |-> done)
    else $error("lost transaction in pipeline");
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy asserted");
endmodule

[tb/bsc_checker.sv]
// Checker that predicts compensated temperature and pressure and compares each result.
`timescale 1ns / 1ps
module bsc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               done,
  input  logic signed [31:0] temperature_centi,
  input  logic [31:0]        pressure_pa,
  input  logic               pressure_valid,
  output int                 errors,
  output int                 pending
);
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        valid;
  } reading_t;

  logic [47:0] cal_t;
  logic [63:0] cal_a;
  logic [63:0] cal_b;
  logic [15:0] cal_p9;
  reading_t    expected_q[$];

  function automatic logic [31:0] sar(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic reading_t compensate(input logic [19:0] rt_in, input logic [19:0] rp_in);
    logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, tf, v3, q, qq, v4, dv, p, s, c1, c2;
    reading_t r;
    rt = {12'd0, rt_in};
    rp = {12'd0, rp_in};
    t1 = {16'd0, cal_t[15:0]};
    t2 = ext16(cal_t[31:16]);
    t3 = ext16(cal_t[47:32]);
    p1 = {16'd0, cal_a[15:0]};
    p2 = ext16(cal_a[31:16]);
    p3 = ext16(cal_a[47:32]);
    p4 = ext16(cal_a[63:48]);
    p5 = ext16(cal_b[15:0]);
    p6 = ext16(cal_b[31:16]);
    p7 = ext16(cal_b[47:32]);
    p8 = ext16(cal_b[63:48]);
    p9 = ext16(cal_p9);
    a = sar(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = sar(sar(d * d, 12) * t3, 14);
    tf = a + b;
    r.temp = sar(tf * 32'd5 + bsc_pkg::TEMP_ROUND, 8);
    v3 = sar(tf, 1) - bsc_pkg::PRESS_OFFSET;
    q = sar(v3, 2);
    qq = q * q;
    v4 = sar(qq, 11) * p6;
    v4 = v4 + ((v3 * p5) << 1);
    v4 = sar(v4, 2) + (p4 << 16);
    v3 = sar(sar(p3 * sar(qq, 13), 3) + sar(p2 * v3, 1), 18);
    dv = sar((bsc_pkg::DIV_BIAS + v3) * p1, 15);
    if (dv == 32'd0) begin
      r.press = 32'd0;
      r.valid = 1'b0;
    end else begin
      p = ((bsc_pkg::PRESS_FULLSCALE - rp) - sar(v4, 12)) * bsc_pkg::PRESS_SCALE;
      if (p < bsc_pkg::PRESS_HALF) p = (p << 1) / dv;
      else p = (p / dv) * 32'd2;
      s = p >> 3;
      c1 = sar(p9 * ((s * s) >> 13), 12);
      c2 = sar((p >> 2) * p8, 13);
      r.press = p + sar(c1 + c2 + p7, 4);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    reading_t e;
    if (rst) begin
      cal_t = '0;
      cal_a = '0;
      cal_b = '0;
      cal_p9 = '0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", temperature_centi, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (temperature_centi !== e.temp) report("temperature_centi", temperature_centi, e.temp);
          if (pressure_pa !== e.press) report("pressure_pa", pressure_pa, e.press);
          if (pressure_valid !== e.valid)
            report("pressure_valid", {31'd0, pressure_valid}, {31'd0, e.valid});
        end
      end
      // A transaction sees the calibration in place before this edge.
      if (start && !busy) expected_q.push_back(compensate(raw_temperature, raw_pressure));
      if (cfg_we) begin
        case (bsc_pkg::reg_index_t'(cfg_index))
          bsc_pkg::REG_TEMP_CAL: cal_t = cfg_data[47:0];
          bsc_pkg::REG_PRESS_A:  cal_a = cfg_data;
          bsc_pkg::REG_PRESS_B:  cal_b = cfg_data;
          bsc_pkg::REG_PRESS_P9: cal_p9 = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end
endmodule

[tb/testbench.sv]
// Top of the barometric compensation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  localparam int LATENCY = 45;
  localparam int WATCHDOG = 2000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [19:0]        raw_temperature;
  logic [19:0]        raw_pressure;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [63:0]        cfg_data;
  logic               done;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_pa;
  logic               pressure_valid;
  int                 errors;
  int                 pending;
  int                 idle_pct;
  int                 quiet_cycles;

  barometric_sensor_compensation u_top (.*);
  bsc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input bsc_pkg::reg_index_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Jittered factory words keep divisor nonzero, pressure in range; else all random.
  task automatic load_calibration(input bit typical);
    logic [15:0] w[12];
    w[0] = 16'd27504; w[1] = 16'd26435; w[2] = -16'sd1000;
    w[3] = 16'd36477; w[4] = -16'sd10685; w[5] = 16'd3024; w[6] = 16'd2855;
    w[7] = 16'd140; w[8] = -16'sd7; w[9] = 16'd15500; w[10] = -16'sd14600;
    w[11] = 16'd6000;
    for (int i = 0; i < 12; i++) begin
      if (typical) w[i] = w[i] + 16'($urandom_range(0, 64)) - 16'd32;
      else w[i] = 16'($urandom);
    end
    write_reg(bsc_pkg::REG_TEMP_CAL, {16'($urandom), w[2], w[1], w[0]});
    write_reg(bsc_pkg::REG_PRESS_A, {w[6], w[5], w[4], w[3]});
    write_reg(bsc_pkg::REG_PRESS_B, {w[10], w[9], w[8], w[7]});
    write_reg(bsc_pkg::REG_PRESS_P9,
              {16'($urandom), 16'($urandom), 16'($urandom), w[11]});
  endtask

  // start stays high after the transaction so that the next one can follow directly.
  task automatic send(input logic [19:0] rt, input logic [19:0] rp);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    raw_temperature = '0;
    raw_pressure = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All-zero calibration gives a zero divisor.
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    drain();
    load_calibration(1'b1);
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'd519888, 20'd415148);
    send(20'h55555, 20'hAAAAA);
    send(20'hAAAAA, 20'h55555);
    send(20'd1, 20'hFFFFE);
    drain();
    // Extreme calibration words.
    write_reg(bsc_pkg::REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bsc_pkg::REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bsc_pkg::REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bsc_pkg::REG_PRESS_P9, 64'hFFFF_FFFF_FFFF_FFFF);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    drain();
    write_reg(bsc_pkg::REG_TEMP_CAL, 64'h8000_8000_0000);
    write_reg(bsc_pkg::REG_PRESS_A, 64'h8000_8000_8000_FFFF);
    write_reg(bsc_pkg::REG_PRESS_B, 64'h7FFF_8000_7FFF_8000);
    write_reg(bsc_pkg::REG_PRESS_P9, 64'h8000);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    send(20'h80000, 20'h80000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 36 : (ph < 8) ? 55 : 0;
      load_calibration(ph % 4 != 3);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 3) != 0)
          send(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 700000)));
        else
          send(20'($urandom), 20'($urandom));
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
